### rtl/utf8sst_pkg.sv
// Shared types and constants for the UTF-8 scalar shift transcoder.
// No dependencies; used by every module of the block.
package utf8sst_pkg;

    localparam int unsigned CAP_W   = 13;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned ACC_W   = 21;
    localparam int unsigned MAX_RES = 4;
    localparam int unsigned RES_W   = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd64;

    localparam logic [ACC_W-1:0] SCALAR_MAX = 21'h10FFFF;
    localparam logic [ACC_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [ACC_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [ACC_W-1:0] MIN_2B     = 21'h000080;
    localparam logic [ACC_W-1:0] MIN_3B     = 21'h000800;
    localparam logic [ACC_W-1:0] MIN_4B     = 21'h010000;
    localparam logic [ACC_W-1:0] MAX_1B     = 21'h00007F;
    localparam logic [ACC_W-1:0] MAX_2B     = 21'h0007FF;
    localparam logic [ACC_W-1:0] MAX_3B     = 21'h00FFFF;

    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_LEAD     = 4'd1,
        ERR_CONT     = 4'd2,
        ERR_TRUNC    = 4'd3,
        ERR_RANGE    = 4'd4,
        ERR_SHIFT    = 4'd5,
        ERR_BADSHIFT = 4'd6,
        ERR_FULL     = 4'd7,
        ERR_COUNT    = 4'd8
    } t_err;

    // Decoder and name bookkeeping state.
    typedef struct packed {
        logic [1:0]       pend;
        logic [ACC_W-1:0] acc;
        logic [1:0]       cls;
        logic [CNT_W-1:0] cnt;
        logic [CAP_W-1:0] len;
        logic             fail;
    } t_state;

    // One input byte's worth of results, bytes[0] goes out first.
    typedef struct packed {
        logic [RES_W-1:0]        num;
        logic [MAX_RES-1:0][7:0] bytes;
        t_err                    err;
        logic                    done;
        logic [CNT_W-1:0]        total;
    } t_burst;

endpackage

### rtl/utf8sst_step.sv
// Single-pass decode / shift / re-encode logic for one source byte.
// Depends on utf8sst_pkg (t_state, t_burst, t_err, range constants).
module utf8sst_step (
    input  utf8sst_pkg::t_state                  i_state,
    input  logic [7:0]                           i_byte,
    input  logic [15:0]                          i_cipher,
    input  logic                                 i_text_end,
    input  logic                                 i_name_start,
    input  logic [utf8sst_pkg::CAP_W-1:0]        i_capacity,
    output utf8sst_pkg::t_state                  o_state,
    output utf8sst_pkg::t_burst                  o_burst
);

    utf8sst_pkg::t_state             s;
    utf8sst_pkg::t_err               err;
    logic                            complete;
    logic [utf8sst_pkg::ACC_W-1:0]   cp;
    logic [utf8sst_pkg::ACC_W-1:0]   min_cp;
    logic [utf8sst_pkg::ACC_W:0]     sum;
    logic [utf8sst_pkg::ACC_W-1:0]   v;
    logic [2:0]                      n_enc;
    logic [3:0][7:0]                 enc;
    logic [utf8sst_pkg::CAP_W:0]     room;
    logic                            full;

    always_comb begin
        // name start clears everything before the byte is looked at
        s = i_state;
        if (i_name_start) begin
            s = '0;
        end

        o_state  = s;
        o_burst  = '0;
        err      = utf8sst_pkg::ERR_NONE;
        complete = 1'b0;
        cp       = '0;
        min_cp   = '0;
        sum      = '0;
        v        = '0;
        n_enc    = 3'd1;
        enc      = '0;
        room     = '0;
        full     = 1'b0;

        if (s.fail) begin
            if (i_text_end) begin
                o_burst.num   = 3'd1;
                o_burst.done  = 1'b1;
                o_burst.total = s.cnt;
                o_state.pend  = '0;
                o_state.acc   = '0;
                o_state.cls   = '0;
                o_state.cnt   = '0;
            end
        end else begin
            if (s.pend == 2'd0) begin
                if (!i_byte[7]) begin
                    cp       = {13'd0, i_byte};
                    complete = 1'b1;
                end else if (i_byte >= 8'hC2 && i_byte <= 8'hDF) begin
                    o_state.pend = 2'd1;
                    o_state.cls  = 2'd1;
                    o_state.acc  = {16'd0, i_byte[4:0]};
                end else if (i_byte >= 8'hE0 && i_byte <= 8'hEF) begin
                    o_state.pend = 2'd2;
                    o_state.cls  = 2'd2;
                    o_state.acc  = {17'd0, i_byte[3:0]};
                end else if (i_byte >= 8'hF0 && i_byte <= 8'hF4) begin
                    o_state.pend = 2'd3;
                    o_state.cls  = 2'd3;
                    o_state.acc  = {18'd0, i_byte[2:0]};
                end else begin
                    err = utf8sst_pkg::ERR_LEAD;
                end
            end else if (i_byte[7:6] != 2'b10) begin
                err = utf8sst_pkg::ERR_CONT;
            end else begin
                o_state.acc  = {s.acc[14:0], i_byte[5:0]};
                o_state.pend = s.pend - 2'd1;
                if (s.pend == 2'd1) begin
                    cp          = {s.acc[14:0], i_byte[5:0]};
                    complete    = 1'b1;
                    o_state.acc = '0;
                    o_state.cls = '0;
                    case (s.cls)
                        2'd1:    min_cp = utf8sst_pkg::MIN_2B;
                        2'd2:    min_cp = utf8sst_pkg::MIN_3B;
                        default: min_cp = utf8sst_pkg::MIN_4B;
                    endcase
                end
            end

            // Shifted scalar and its encoding
            sum = {1'b0, cp} + {6'd0, i_cipher};
            v   = sum[utf8sst_pkg::ACC_W-1:0];
            if (v <= utf8sst_pkg::MAX_1B) begin
                n_enc  = 3'd1;
                enc[0] = v[7:0];
            end else if (v <= utf8sst_pkg::MAX_2B) begin
                n_enc  = 3'd2;
                enc[0] = {3'b110, v[10:6]};
                enc[1] = {2'b10, v[5:0]};
            end else if (v <= utf8sst_pkg::MAX_3B) begin
                n_enc  = 3'd3;
                enc[0] = {4'b1110, v[15:12]};
                enc[1] = {2'b10, v[11:6]};
                enc[2] = {2'b10, v[5:0]};
            end else begin
                n_enc  = 3'd4;
                enc[0] = {5'b11110, v[20:18]};
                enc[1] = {2'b10, v[17:12]};
                enc[2] = {2'b10, v[11:6]};
                enc[3] = {2'b10, v[5:0]};
            end
            room = {1'b0, i_capacity} - {1'b0, s.len};
            full = (i_capacity <= s.len) ||
                   ({10'd0, n_enc} >= room[utf8sst_pkg::CAP_W-1:0]);

            if (err == utf8sst_pkg::ERR_NONE) begin
                if (!complete) begin
                    if (i_text_end) begin
                        err = utf8sst_pkg::ERR_TRUNC;
                    end
                end else if (cp < min_cp || cp > utf8sst_pkg::SCALAR_MAX ||
                             (cp >= utf8sst_pkg::SURR_LO && cp <= utf8sst_pkg::SURR_HI)) begin
                    err = utf8sst_pkg::ERR_RANGE;
                end else if (sum > {1'b0, utf8sst_pkg::SCALAR_MAX}) begin
                    err = utf8sst_pkg::ERR_SHIFT;
                end else if (v == '0 ||
                             (v >= utf8sst_pkg::SURR_LO && v <= utf8sst_pkg::SURR_HI)) begin
                    err = utf8sst_pkg::ERR_BADSHIFT;
                end else if (full) begin
                    err = utf8sst_pkg::ERR_FULL;
                end else if (s.cnt == {utf8sst_pkg::CNT_W{1'b1}}) begin
                    err = utf8sst_pkg::ERR_COUNT;
                end
            end

            if (err != utf8sst_pkg::ERR_NONE) begin
                // decoder contents do not matter once the name has failed
                o_state.fail  = 1'b1;
                o_state.pend  = '0;
                o_state.acc   = '0;
                o_state.cls   = '0;
                o_burst.num   = 3'd1;
                o_burst.err   = err;
                o_burst.done  = i_text_end;
                o_burst.total = i_text_end ? s.cnt : '0;
                if (i_text_end) begin
                    o_state.cnt = '0;
                end
            end else if (complete) begin
                o_state.len   = s.len + {10'd0, n_enc};
                o_state.cnt   = s.cnt + 16'd1;
                o_burst.num   = n_enc;
                o_burst.bytes = enc;
                o_burst.done  = i_text_end;
                o_burst.total = i_text_end ? (s.cnt + 16'd1) : '0;
                if (i_text_end) begin
                    o_state.pend = '0;
                    o_state.acc  = '0;
                    o_state.cls  = '0;
                    o_state.cnt  = '0;
                end
            end
        end
    end

endmodule

### rtl/utf8sst_emit.sv
// Result register: holds one byte's burst and hands it out one beat per cycle while i_out_ready is high.
// Depends on utf8sst_pkg (t_burst, t_err).
module utf8sst_emit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  utf8sst_pkg::t_burst              i_burst,
    input  logic                             i_out_ready,
    output logic                             o_can_load,
    output logic                             o_out_valid,
    output logic [7:0]                       o_out_byte,
    output logic                             o_last_of_run,
    output logic [3:0]                       o_error_code,
    output logic                             o_text_done,
    output logic [15:0]                      o_scalar_total
);

    logic [utf8sst_pkg::RES_W-1:0] r_left, n_left;
    utf8sst_pkg::t_burst           r_burst, n_burst;
    logic                          pop;
    logic                          last;

    assign last        = (r_left == 3'd1);
    assign pop         = o_out_valid && i_out_ready;
    assign o_can_load  = (r_left == 3'd0) || (last && i_out_ready);
    assign o_out_valid = (r_left != 3'd0);

    always_comb begin
        n_left  = r_left;
        n_burst = r_burst;
        if (i_load) begin
            n_left  = i_burst.num;
            n_burst = i_burst;
        end else if (pop) begin
            n_left        = r_left - 3'd1;
            n_burst.bytes = {8'd0, r_burst.bytes[3:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_burst <= n_burst;
    end

    assign o_out_byte     = r_burst.bytes[0];
    assign o_last_of_run  = last;
    assign o_error_code   = r_burst.err;
    assign o_text_done    = r_burst.done && last;
    assign o_scalar_total = (r_burst.done && last) ? r_burst.total : '0;

endmodule

### rtl/utf8_scalar_shift_transcoder_unit.sv
// Throughput: one source byte per cycle while each byte yields at most one result
// and i_out_ready is high; a byte yielding n encoded bytes holds the output register
// until all n are taken. Path: input register, step logic, then result register.
// Reset (i_rst_n low, synchronous): empties both stages, clears decoder and
// name state, capacity returns to 64.
// Depends on utf8sst_pkg, utf8sst_step and utf8sst_emit.
module utf8_scalar_shift_transcoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: name capacity
    input  logic        i_cfg_wen,
    input  logic [12:0] i_cfg_wdata,
    // source byte channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic [15:0] i_cipher_offset,
    input  logic        i_text_end,
    input  logic        i_name_start,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic [3:0]  o_error_code,
    output logic        o_text_done,
    output logic [15:0] o_scalar_total
);

    logic [utf8sst_pkg::CAP_W-1:0] r_capacity;

    // Input register: one source beat waiting for the step logic.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [15:0] r_cipher;
    logic        r_text_end;
    logic        r_name_start;

    utf8sst_pkg::t_state r_state, n_state;
    utf8sst_pkg::t_burst burst;

    logic can_load;
    logic consume;    // input register moves through the step logic this cycle

    assign consume    = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= utf8sst_pkg::CAP_RESET;
        end else if (i_cfg_wen) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte    <= i_in_byte;
            r_cipher     <= i_cipher_offset;
            r_text_end   <= i_text_end;
            r_name_start <= i_name_start;
        end
    end

    // Decoder / name state advances only when a beat is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    utf8sst_step u_step (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_cipher     (r_cipher),
        .i_text_end   (r_text_end),
        .i_name_start (r_name_start),
        .i_capacity   (r_capacity),
        .o_state      (n_state),
        .o_burst      (burst)
    );

    // A burst of zero results leaves the result register empty.
    utf8sst_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (consume),
        .i_burst        (burst),
        .i_out_ready    (i_out_ready),
        .o_can_load     (can_load),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_error_code   (o_error_code),
        .o_text_done    (o_text_done),
        .o_scalar_total (o_scalar_total)
    );

endmodule

### rtl/utf8sst_checker.sv
// Port-level checks for the transcoder, attached by bind.
// Depends on utf8sst_pkg (t_err) and the top level's port names.
module utf8sst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_last_of_run,
    input logic [3:0]  o_error_code,
    input logic        o_text_done,
    input logic [15:0] o_scalar_total
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte))
        else $error("result beat changed while stalled");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != utf8sst_pkg::ERR_NONE |->
            o_last_of_run && o_out_byte == 8'd0)
        else $error("error beat is not a lone zero byte");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_text_done |-> o_last_of_run)
        else $error("text_done off the final beat");

    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_text_done |-> o_scalar_total == 16'd0)
        else $error("scalar_total set without text_done");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_error_code <= utf8sst_pkg::ERR_COUNT)
        else $error("error code out of range");

endmodule

bind utf8_scalar_shift_transcoder_unit utf8sst_checker u_utf8sst_checker (.*);
